// ----- design/es2utc_pkg.sv -----
// Shared types and constants for the epoch-seconds to UTC date converter.
// Holds the pipeline stage map, reciprocal constants and the month table.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package es2utc_pkg;

    // Field widths.
    localparam int SECS_W   = 32;
    localparam int Q60_W    = 27;
    localparam int Q3600_W  = 21;
    localparam int DAYS_W   = 16;
    localparam int DOE_W    = 18;
    localparam int YOE_W    = 9;
    localparam int DOY_W    = 9;
    localparam int MONTH_W  = 4;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 40;

    // Pipeline stage map. Stage 0 is the input register, the last one the result register.
    localparam int NUM_STAGES = 9;
    localparam int STG_IN     = 0;
    localparam int STG_Q60    = 1;
    localparam int STG_Q3600  = 2;
    localparam int STG_DAYS   = 3;
    localparam int STG_DOE    = 4;
    localparam int STG_T      = 5;
    localparam int STG_YOE    = 6;
    localparam int STG_DOY    = 7;
    localparam int STG_OUT    = 8;

    // Time constants.
    localparam int SECS_PER_MIN  = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY = 24;

    // Division by 60 is a shift by two and a multiply by the rounded-up reciprocal of 15.
    localparam int SEC_SHIFT   = 34;
    localparam int RECIP_SEC_W = 31;
    localparam logic [RECIP_SEC_W-1:0] RECIP_SEC =
        RECIP_SEC_W'(((64'd1 << SEC_SHIFT) + 64'd14) / 64'd15);

    localparam int MIN_SHIFT   = 29;
    localparam int RECIP_MIN_W = 26;
    localparam logic [RECIP_MIN_W-1:0] RECIP_MIN =
        RECIP_MIN_W'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

    // Division of hours by 24 is a shift by three and a multiply by the reciprocal of 3.
    localparam int DAY_SHIFT   = 20;
    localparam int RECIP_DAY_W = 19;
    localparam logic [RECIP_DAY_W-1:0] RECIP_DAY =
        RECIP_DAY_W'(((64'd1 << DAY_SHIFT) + 64'd2) / 64'd3);

    // Calendar constants. Days are counted in 400-year eras that start on March 1st.
    localparam int ERA2000_DAY    = 11017;   // days from 1970-01-01 to 2000-03-01
    localparam int ERA1600_OFFSET = 135080;  // day of era of 1970-01-01 in the 1600 era
    localparam int ERA_LAST_DAY   = 146096;
    localparam int CENTURY_DAYS   = 36524;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int ERA2000_YEAR   = 2000;
    localparam int ERA1600_YEAR   = 1600;
    localparam int YEAR_BIAS      = 1900;
    localparam int YEARS_PER_CENT = 100;
    localparam int MONTHS         = 12;
    localparam int MONTH_WRAP     = 10;      // months from March before the next year begins

    // Division by 1460 is a shift by two and a multiply by the reciprocal of 365.
    localparam int Y4_SHIFT     = 25;
    localparam int RECIP_Y4_W   = 17;
    localparam logic [RECIP_Y4_W-1:0] RECIP_Y4 =
        RECIP_Y4_W'(((64'd1 << Y4_SHIFT) + 64'd364) / 64'd365);
    localparam int Q1460_W      = 7;

    localparam int YEAR_SHIFT   = 26;
    localparam int RECIP_YEAR_W = 18;
    localparam logic [RECIP_YEAR_W-1:0] RECIP_YEAR =
        RECIP_YEAR_W'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    // First day of each month, counted from March 1st.
    localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] valid;
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } tod_t;

    typedef struct packed {
        logic [7:0]         year_since_1900;
        logic [MONTH_W-1:0] month_index;
        logic [4:0]         day_of_month;
        tod_t               tod;
    } utc_t;

endpackage

// ----- design/epoch_seconds_to_utc_date.sv -----
// Top level of the epoch-seconds to UTC date converter: handshake and stage control.
// Instantiates es2utc_time_split and es2utc_date_calc; uses es2utc_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  epoch_seconds
//  m_axis    out        m_axis_tvalid / m_axis_tready  year, month, day, hour, minute, second
//
// The converter accepts one transaction per clock cycle while no stall holds it back,
// and carries it through the nine-register pipeline from the input register
// through the reciprocal multiplies to the result register.
// Each stage holds its own valid bit, so a stalled result only halts the stages
// behind it and empty stages keep filling; while the result waits, input is still
// taken as long as some stage is empty.
// Reset clears all valid bits, and no transaction is accepted while reset is held.

module epoch_seconds_to_utc_date
    import es2utc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] epoch_seconds
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] year_since_1900, [11:8] month_index, [16:12] day_of_month,
    // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute,
    // [39:34] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic                  run_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    logic                  in_acc;
    logic                  out_acc;
    logic [SECS_W-1:0]     secs_reg;
    pipe_ctrl_t            ctrl;
    logic [DAYS_W-1:0]     days;
    tod_t                  tod;
    utc_t                  result;

    // A stage may load when it is empty or when the stage after it loads too.
    // The result stage loads when it is empty or its result is being taken.
    always_comb
    begin
        load[STG_OUT] = !valid_reg[STG_OUT] || m_axis_tready;
        for (int k = STG_OUT - 1; k >= STG_IN; k--)
        begin
            load[k] = !valid_reg[k] || load[k + 1];
        end
    end

    assign s_axis_tready = load[STG_IN] && run_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load[STG_IN])
        begin
            valid_next[STG_IN] = in_acc;
        end
        for (int k = STG_IN + 1; k <= STG_OUT; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            run_reg   <= 1'b1;
            valid_reg <= valid_next;
        end
    end

    // Input register; the payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            secs_reg <= s_axis_tdata[SECS_W-1:0];
        end
    end

    assign ctrl.valid = valid_reg;
    assign ctrl.load  = load;

    es2utc_time_split u_time_split (
        .clk  (clk),
        .ctrl (ctrl),
        .secs (secs_reg),
        .days (days),
        .tod  (tod)
    );

    es2utc_date_calc u_date_calc (
        .clk    (clk),
        .ctrl   (ctrl),
        .days   (days),
        .tod    (tod),
        .result (result)
    );

    assign m_axis_tvalid = valid_reg[STG_OUT];
    assign m_axis_tdata  = {
        6'b0,
        result.tod.second_of_minute,
        result.tod.minute_of_hour,
        result.tod.hour_of_day,
        result.day_of_month,
        result.month_index,
        result.year_since_1900
    };

`ifndef SYNTH
    // A pipeline with any empty stage must be able to take a transaction.
    a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !(&valid_reg)) |-> s_axis_tready)
        else $error("input stalled although a stage is empty");

    // Items in flight change only by accepted and delivered transactions.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |=> ($countones(valid_reg) == $past($countones(valid_reg))
            + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("transaction lost or duplicated in the pipeline");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result.tod.hour_of_day < 5'(HOURS_PER_DAY))
            && (result.tod.minute_of_hour < 6'(MIN_PER_HOUR))
            && (result.tod.second_of_minute < 6'(SECS_PER_MIN)))
        else $error("time of day out of range");
`endif

endmodule

// ----- design/es2utc_time_split.sv -----
// Splits the seconds count into whole days and hour, minute, second of the day.
// Three pipeline stages, one reciprocal multiply each; uses es2utc_pkg.
`timescale 1ns / 1ps

module es2utc_time_split
    import es2utc_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [SECS_W-1:0] secs,
    output logic [DAYS_W-1:0] days,
    output tod_t              tod
);

    localparam int P1_W = SECS_W - 2 + RECIP_SEC_W;
    localparam int P2_W = Q60_W - 2 + RECIP_MIN_W;
    localparam int P3_W = Q3600_W - 3 + RECIP_DAY_W;

    logic [P1_W-1:0]    p1;
    logic [P2_W-1:0]    p2;
    logic [P3_W-1:0]    p3;

    logic [Q60_W-1:0]   q60_next;
    logic [Q60_W-1:0]   q60_reg;
    logic [5:0]         secs_lo_reg;

    logic [Q3600_W-1:0] q3600_next;
    logic [Q3600_W-1:0] q3600_reg;
    logic [5:0]         q60_lo_reg;
    logic [5:0]         sec_next;
    logic [5:0]         sec_reg;

    logic [DAYS_W-1:0]  days_next;
    logic [DAYS_W-1:0]  days_reg;
    logic [5:0]         min_next;
    logic [4:0]         hour_next;
    tod_t               tod_reg;

    always_comb
    begin
        // Total minutes, then seconds as the low bits left over.
        p1        = P1_W'(secs[SECS_W-1:2]) * P1_W'(RECIP_SEC);
        q60_next  = p1[SEC_SHIFT +: Q60_W];

        // Total hours, and the seconds left over from the minute split.
        p2         = P2_W'(q60_reg[Q60_W-1:2]) * P2_W'(RECIP_MIN);
        q3600_next = p2[MIN_SHIFT +: Q3600_W];
        sec_next   = secs_lo_reg - 6'(q60_reg[3:0] * 6'(SECS_PER_MIN));

        // Whole days; the remainders fit in a few low bits, so they wrap safely.
        p3        = P3_W'(q3600_reg[Q3600_W-1:3]) * P3_W'(RECIP_DAY);
        days_next = p3[DAY_SHIFT +: DAYS_W];
        min_next  = q60_lo_reg - 6'(q3600_reg[3:0] * 6'(MIN_PER_HOUR));
        hour_next = q3600_reg[4:0] - 5'(days_next[1:0] * 5'(HOURS_PER_DAY));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[STG_Q60])
        begin
            q60_reg     <= q60_next;
            secs_lo_reg <= secs[5:0];
        end
        if (ctrl.load[STG_Q3600])
        begin
            q3600_reg  <= q3600_next;
            q60_lo_reg <= q60_reg[5:0];
            sec_reg    <= sec_next;
        end
        if (ctrl.load[STG_DAYS])
        begin
            days_reg                 <= days_next;
            tod_reg.hour_of_day      <= hour_next;
            tod_reg.minute_of_hour   <= min_next;
            tod_reg.second_of_minute <= sec_reg;
        end
    end

    assign days = days_reg;
    assign tod  = tod_reg;

endmodule

// ----- design/es2utc_date_calc.sv -----
// Converts a day count since 1970-01-01 into Gregorian year, month and day.
// Five pipeline stages ending in the result register; uses es2utc_pkg.
`timescale 1ns / 1ps

module es2utc_date_calc
    import es2utc_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [DAYS_W-1:0] days,
    input  tod_t              tod,
    output utc_t              result
);

    localparam int P5_W = DOE_W - 2 + RECIP_Y4_W;
    localparam int P6_W = DOE_W + RECIP_YEAR_W;

    // Stage 4: position within the 400-year era.
    logic               era_next;
    logic [DOE_W-1:0]   doe_next;
    logic               era_s4_reg;
    logic [DOE_W-1:0]   doe_s4_reg;
    tod_t               tod_s4_reg;

    // Stage 5: day of era with leap days removed.
    logic [P5_W-1:0]    p5;
    logic [Q1460_W-1:0] q1460;
    logic [2:0]         cents;
    logic               era_end;
    logic [DOE_W-1:0]   t_next;
    logic               era_s5_reg;
    logic [DOE_W-1:0]   doe_s5_reg;
    logic [DOE_W-1:0]   t_s5_reg;
    tod_t               tod_s5_reg;

    // Stage 6: year of era.
    logic [P6_W-1:0]    p6;
    logic [YOE_W-1:0]   yoe_next;
    logic               era_s6_reg;
    logic [DOE_W-1:0]   doe_s6_reg;
    logic [YOE_W-1:0]   yoe_s6_reg;
    tod_t               tod_s6_reg;

    // Stage 7: day of year counted from March 1st.
    logic [1:0]         cent_years;
    logic [DOE_W-1:0]   yday;
    logic [DOY_W-1:0]   doy_next;
    logic               era_s7_reg;
    logic [YOE_W-1:0]   yoe_s7_reg;
    logic [DOY_W-1:0]   doy_s7_reg;
    tod_t               tod_s7_reg;

    // Stage 8: month and day, year relative to 1900.
    logic [MONTH_W-1:0] mp;
    logic               next_year;
    utc_t               result_next;
    utc_t               result_reg;

    always_comb
    begin
        era_next = (days >= DAYS_W'(ERA2000_DAY));
        if (era_next)
        begin
            doe_next = DOE_W'(days) - DOE_W'(ERA2000_DAY);
        end
        else
        begin
            doe_next = DOE_W'(days) + DOE_W'(ERA1600_OFFSET);
        end
    end

    always_comb
    begin
        p5      = P5_W'(doe_s4_reg[DOE_W-1:2]) * P5_W'(RECIP_Y4);
        q1460   = p5[Y4_SHIFT +: Q1460_W];
        cents   = 3'(doe_s4_reg >= DOE_W'(CENTURY_DAYS))
                + 3'(doe_s4_reg >= DOE_W'(2 * CENTURY_DAYS))
                + 3'(doe_s4_reg >= DOE_W'(3 * CENTURY_DAYS))
                + 3'(doe_s4_reg >= DOE_W'(ERA_LAST_DAY));
        era_end = (doe_s4_reg == DOE_W'(ERA_LAST_DAY));
        t_next  = doe_s4_reg - DOE_W'(q1460) + DOE_W'(cents) - DOE_W'(era_end);
    end

    always_comb
    begin
        p6       = P6_W'(t_s5_reg) * P6_W'(RECIP_YEAR);
        yoe_next = p6[YEAR_SHIFT +: YOE_W];
    end

    always_comb
    begin
        cent_years = 2'(yoe_s6_reg >= YOE_W'(YEARS_PER_CENT))
                   + 2'(yoe_s6_reg >= YOE_W'(2 * YEARS_PER_CENT))
                   + 2'(yoe_s6_reg >= YOE_W'(3 * YEARS_PER_CENT));
        yday       = doe_s6_reg
                   - DOE_W'(yoe_s6_reg) * DOE_W'(DAYS_PER_YEAR)
                   - DOE_W'(yoe_s6_reg >> 2)
                   + DOE_W'(cent_years);
        doy_next   = yday[DOY_W-1:0];
    end

    always_comb
    begin
        mp = '0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (doy_s7_reg >= MONTH_START[i])
            begin
                mp = MONTH_W'(i);
            end
        end
        next_year = (mp >= MONTH_W'(MONTH_WRAP));

        result_next.day_of_month = 5'(doy_s7_reg - MONTH_START[mp] + 9'd1);
        if (next_year)
        begin
            result_next.month_index = mp - MONTH_W'(MONTH_WRAP);
        end
        else
        begin
            result_next.month_index = mp + MONTH_W'(MONTHS - MONTH_WRAP);
        end
        if (era_s7_reg)
        begin
            result_next.year_since_1900 = yoe_s7_reg[7:0] + 8'(next_year)
                                        + 8'(ERA2000_YEAR - YEAR_BIAS);
        end
        else
        begin
            result_next.year_since_1900 = yoe_s7_reg[7:0] + 8'(next_year)
                                        + 8'(ERA1600_YEAR - YEAR_BIAS);
        end
        result_next.tod = tod_s7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[STG_DOE])
        begin
            era_s4_reg <= era_next;
            doe_s4_reg <= doe_next;
            tod_s4_reg <= tod;
        end
        if (ctrl.load[STG_T])
        begin
            era_s5_reg <= era_s4_reg;
            doe_s5_reg <= doe_s4_reg;
            t_s5_reg   <= t_next;
            tod_s5_reg <= tod_s4_reg;
        end
        if (ctrl.load[STG_YOE])
        begin
            era_s6_reg <= era_s5_reg;
            doe_s6_reg <= doe_s5_reg;
            yoe_s6_reg <= yoe_next;
            tod_s6_reg <= tod_s5_reg;
        end
        if (ctrl.load[STG_DOY])
        begin
            era_s7_reg <= era_s6_reg;
            yoe_s7_reg <= yoe_s6_reg;
            doy_s7_reg <= doy_next;
            tod_s7_reg <= tod_s6_reg;
        end
        if (ctrl.load[STG_OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

`ifndef SYNTH
    a_doe_range: assert property (@(posedge clk)
        ctrl.valid[STG_DOE] |-> doe_s4_reg <= DOE_W'(ERA_LAST_DAY))
        else $error("day of era out of range");

    a_doy_range: assert property (@(posedge clk)
        ctrl.valid[STG_DOY] |-> doy_s7_reg <= DOY_W'(DAYS_PER_YEAR))
        else $error("day of year out of range");

    a_date_range: assert property (@(posedge clk)
        ctrl.valid[STG_OUT] |-> (result_reg.month_index <= MONTH_W'(MONTHS - 1))
            && (result_reg.day_of_month >= 5'd1) && (result_reg.day_of_month <= 5'd31))
        else $error("month or day out of range");
`endif

endmodule
